>>> rtl/core/m7ta_pkg.sv
// Shared types, constants and helper functions of the Mode 7 texel address unit.
// Used by every module of the block; depends on nothing else.
package m7ta_pkg;

   localparam int DIV_BITS = 27;
   localparam int DEN_W = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int LATENCY = DIV_BITS + 6;

   localparam logic [2:0] REG_FOCAL_LENGTH = 3'd0;
   localparam logic [2:0] REG_HORIZON = 3'd1;
   localparam logic [2:0] REG_GROUND_SCALE = 3'd2;
   localparam logic [2:0] REG_X_OFFSET = 3'd3;
   localparam logic [2:0] REG_Y_OFFSET = 3'd4;
   localparam logic [2:0] REG_COS_ANGLE = 3'd5;
   localparam logic [2:0] REG_SIN_ANGLE = 3'd6;
   localparam logic [2:0] REG_SKY_SCROLL = 3'd7;

   localparam logic [7:0] FOG_ROW_BASE = 8'd60;
   localparam logic [7:0] FOG_ROW_CLAMP = 8'd159;
   localparam logic [13:0] FOG_SLOPE = 14'd100;
   localparam logic [31:0] FOG_RECIP_110 = 32'd152521;
   localparam logic signed [9:0] FOG_BIAS = 10'sd10;
   localparam logic signed [9:0] FOG_MIN = -10'sd100;
   localparam logic [8:0] FOG_MASK = 9'd505;

   typedef struct packed {
      logic [9:0] focal_length;
      logic [8:0] horizon;
      logic [15:0] sky_scroll;
   } front_cfg_type;

   typedef struct packed {
      logic [9:0] ground_scale;
      logic signed [23:0] x_offset;
      logic signed [23:0] y_offset;
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
   } back_cfg_type;

   typedef struct packed {
      logic is_sky;
      logic bad;
      logic [9:0] sky_u;
      logic [7:0] row;
      logic [8:0] fog;
      logic neg_x;
      logic neg_y;
   } ctl_type;

   typedef struct packed {
      ctl_type ctl;
      logic [DIV_BITS-1:0] wx;
      logic [DIV_BITS-1:0] wy;
      logic [DEN_W-1:0] den;
   } item_type;

   typedef struct packed {
      ctl_type ctl;
      logic [DIV_BITS-1:0] wx;
      logic [DIV_BITS-1:0] wy;
      logic [DEN_W-1:0] remx;
      logic [DEN_W-1:0] remy;
      logic [DEN_W-1:0] den;
   } div_type;

   function automatic div_type div_step(input div_type a);
      div_type r;
      logic [DEN_W:0] tx;
      logic [DEN_W:0] ty;
      logic gx;
      logic gy;
      r = a;
      tx = {a.remx, a.wx[DIV_BITS-1]};
      ty = {a.remy, a.wy[DIV_BITS-1]};
      gx = tx >= {1'b0, a.den};
      gy = ty >= {1'b0, a.den};
      r.remx = gx ? DEN_W'(tx - {1'b0, a.den}) : tx[DEN_W-1:0];
      r.remy = gy ? DEN_W'(ty - {1'b0, a.den}) : ty[DEN_W-1:0];
      r.wx = {a.wx[DIV_BITS-2:0], gx};
      r.wy = {a.wy[DIV_BITS-2:0], gy};
      return r;
   endfunction

   // Division by 110 is a multiply by a rounded-up reciprocal, exact for these ranges.
   function automatic logic [8:0] fog_of_row(input logic [7:0] row);
      logic [13:0] d;
      logic [31:0] prod;
      logic [6:0] q;
      logic signed [9:0] f;
      d = '0;
      if (row >= FOG_ROW_CLAMP) begin
         f = FOG_MIN;
      end else if (row >= FOG_ROW_BASE) begin
         d = 14'(row - FOG_ROW_BASE) * FOG_SLOPE;
         prod = 32'(d) * FOG_RECIP_110;
         q = prod[30:24];
         f = -FOG_BIAS - $signed({3'b000, q});
      end else begin
         d = 14'(FOG_ROW_BASE - row) * FOG_SLOPE;
         prod = 32'(d) * FOG_RECIP_110;
         q = prod[30:24];
         f = $signed({3'b000, q}) - FOG_BIAS;
         if (f > 10'sd0) begin
            f = 10'sd0;
         end
      end
      return f[8:0] & FOG_MASK;
   endfunction

endpackage

>>> rtl/core/m7ta_front.sv
// Front part: takes a request, classifies sky or ground and prepares the divider operands.
// Depends on m7ta_pkg.
module m7ta_front #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240,
   parameter int SKY_ROWS = 70,
   parameter int SKY_W_LOG2 = 9
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [8:0] pixel_col,
   input  logic [7:0] pixel_row,
   input  m7ta_pkg::front_cfg_type cfg,
   output logic out_valid,
   output m7ta_pkg::item_type out_item
);

   logic vld_ff, vld_in;
   m7ta_pkg::item_type item_ff, item_in;

   logic ground;
   logic signed [10:0] cx;
   logic signed [10:0] cy;
   logic signed [11:0] num;
   logic signed [11:0] den;
   logic [9:0] mag_x;
   logic [10:0] mag_y;
   logic [16:0] ssum;

   always_comb begin
      ground = {3'b000, pixel_row} >= 11'(SKY_ROWS);
      cx = $signed({2'b00, pixel_col}) - $signed(11'(SCREEN_W / 2));
      cy = $signed({3'b000, pixel_row}) - $signed(11'(SCREEN_H / 2));
      num = $signed({cy[10], cy}) + $signed({2'b00, cfg.focal_length});
      den = $signed({cy[10], cy}) + $signed({3'b000, cfg.horizon});
      mag_x = cx[10] ? 10'(-cx) : 10'(cx);
      mag_y = num[11] ? 11'(-num) : 11'(num);
      ssum = {8'd0, pixel_col} + {1'b0, cfg.sky_scroll};

      vld_in = in_valid;
      item_in.ctl.is_sky = !ground;
      item_in.ctl.bad = ground && (den[11] || den == 12'sd0);
      item_in.ctl.sky_u = 10'(ssum[SKY_W_LOG2-1:0]);
      item_in.ctl.row = pixel_row;
      item_in.ctl.fog = ground ? m7ta_pkg::fog_of_row(pixel_row) : 9'd0;
      item_in.ctl.neg_x = cx[10];
      item_in.ctl.neg_y = !num[11] && num != 12'sd0;
      item_in.wx = {1'b0, mag_x, 16'd0};
      item_in.wy = {mag_y, 16'd0};
      item_in.den = den[9:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = vld_ff;
   assign out_item = item_ff;

endmodule

>>> rtl/core/m7ta_queue.sv
// Short request queue between the front and the back part.
// Depends on m7ta_pkg.
module m7ta_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  m7ta_pkg::item_type push_item,
   input  logic pop,
   output logic full,
   output logic out_valid,
   output m7ta_pkg::item_type out_item
);

   m7ta_pkg::item_type entries_ff [m7ta_pkg::QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      do_pop = pop && count_ff != 2'd0;
      do_push = push && (count_ff != 2'(m7ta_pkg::QUEUE_DEPTH) || do_pop);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full = count_ff == 2'(m7ta_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != 2'd0;
   assign out_item = entries_ff[rd_ptr_ff];

endmodule

>>> rtl/core/m7ta_back.sv
// Back part: pipelined divider, rotation, scaling and texture wrap.
// Depends on m7ta_pkg.
module m7ta_back #(
   parameter int TEX_W_LOG2 = 8,
   parameter int TEX_H_LOG2 = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  m7ta_pkg::item_type in_item,
   input  m7ta_pkg::back_cfg_type cfg,
   output logic out_valid,
   output logic is_sky,
   output logic [9:0] tex_u,
   output logic [9:0] tex_v,
   output logic [8:0] fog_alpha,
   output logic depth_invalid
);

   localparam int N = m7ta_pkg::DIV_BITS;

   logic [N-1:0] dvld_ff, dvld_in;
   m7ta_pkg::div_type stg_ff [N];
   m7ta_pkg::div_type stg_in [N];
   m7ta_pkg::div_type first;

   logic signed [27:0] qx, qy;
   logic p_vld_ff;
   m7ta_pkg::ctl_type p_ctl_ff;
   logic signed [43:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic signed [43:0] pxc_in, pys_in, pxs_in, pyc_in;

   logic r_vld_ff;
   m7ta_pkg::ctl_type r_ctl_ff;
   logic signed [44:0] rx_ff, ry_ff, rx_in, ry_in;

   logic s_vld_ff;
   m7ta_pkg::ctl_type s_ctl_ff;
   logic signed [57:0] sx_ff, sy_ff, sx_in, sy_in;
   logic signed [55:0] prx, pry;
   logic signed [10:0] scl;
   logic signed [57:0] ox, oy;

   logic [TEX_W_LOG2-1:0] ubits;
   logic [TEX_H_LOG2-1:0] vbits;
   logic adj_x, adj_y;

   logic vld_ff;
   logic sky_ff, sky_in;
   logic [9:0] u_ff, u_in, v_ff, v_in;
   logic [8:0] fog_ff, fog_in;
   logic bad_ff, bad_in;

   always_comb begin
      first.ctl = in_item.ctl;
      first.wx = in_item.wx;
      first.wy = in_item.wy;
      first.remx = '0;
      first.remy = '0;
      first.den = in_item.den;
      stg_in[0] = m7ta_pkg::div_step(first);
      for (int s = 1; s < N; s++) begin
         stg_in[s] = m7ta_pkg::div_step(stg_ff[s-1]);
      end
      dvld_in = {dvld_ff[N-2:0], in_valid};
   end

   always_comb begin
      qx = stg_ff[N-1].ctl.neg_x ? -$signed({1'b0, stg_ff[N-1].wx})
                                 : $signed({1'b0, stg_ff[N-1].wx});
      qy = stg_ff[N-1].ctl.neg_y ? -$signed({1'b0, stg_ff[N-1].wy})
                                 : $signed({1'b0, stg_ff[N-1].wy});
      pxc_in = qx * cfg.cos_angle;
      pys_in = qy * cfg.sin_angle;
      pxs_in = qx * cfg.sin_angle;
      pyc_in = qy * cfg.cos_angle;

      rx_in = $signed({pxc_ff[43], pxc_ff}) - $signed({pys_ff[43], pys_ff});
      ry_in = $signed({pxs_ff[43], pxs_ff}) + $signed({pyc_ff[43], pyc_ff});

      scl = $signed({1'b0, cfg.ground_scale});
      prx = rx_ff * scl;
      pry = ry_ff * scl;
      ox = {{12{cfg.x_offset[23]}}, cfg.x_offset, 22'd0};
      oy = {{12{cfg.y_offset[23]}}, cfg.y_offset, 22'd0};
      sx_in = $signed({{2{prx[55]}}, prx}) + ox;
      sy_in = $signed({{2{pry[55]}}, pry}) + oy;

      adj_x = sx_ff[57] && (sx_ff[29:0] != 30'd0);
      adj_y = sy_ff[57] && (sy_ff[29:0] != 30'd0);
      ubits = sx_ff[30 +: TEX_W_LOG2] + TEX_W_LOG2'(adj_x);
      vbits = sy_ff[30 +: TEX_H_LOG2] + TEX_H_LOG2'(adj_y);

      sky_in = s_ctl_ff.is_sky;
      fog_in = s_ctl_ff.fog;
      bad_in = s_ctl_ff.bad;
      if (s_ctl_ff.is_sky) begin
         u_in = s_ctl_ff.sky_u;
         v_in = {2'b00, s_ctl_ff.row};
      end else if (s_ctl_ff.bad) begin
         u_in = 10'd0;
         v_in = 10'd0;
      end else begin
         u_in = 10'(ubits);
         v_in = 10'(vbits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff <= '0;
         p_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         dvld_ff <= dvld_in;
         p_vld_ff <= dvld_ff[N-1];
         r_vld_ff <= p_vld_ff;
         s_vld_ff <= r_vld_ff;
         vld_ff <= s_vld_ff;
      end
      for (int s = 0; s < N; s++) begin
         stg_ff[s] <= stg_in[s];
      end
      p_ctl_ff <= stg_ff[N-1].ctl;
      pxc_ff <= pxc_in;
      pys_ff <= pys_in;
      pxs_ff <= pxs_in;
      pyc_ff <= pyc_in;
      r_ctl_ff <= p_ctl_ff;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      s_ctl_ff <= r_ctl_ff;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sky_ff <= sky_in;
      u_ff <= u_in;
      v_ff <= v_in;
      fog_ff <= fog_in;
      bad_ff <= bad_in;
   end

   assign out_valid = vld_ff;
   assign is_sky = sky_ff;
   assign tex_u = u_ff;
   assign tex_v = v_ff;
   assign fog_alpha = fog_ff;
   assign depth_invalid = bad_ff;

endmodule

>>> rtl/core/mode7_texel_address_unit.sv
// A request passes front register, queue and back part to a one-cycle rsp_valid strobe.
// Throughput: one request per cycle, set by the 27-stage one-bit-per-stage divider.
// busy never rises: the back part takes a request from the queue every cycle.
// Reset is synchronous: it empties the pipeline and queue and reloads register defaults.
// Top level; instantiates m7ta_front, m7ta_queue and m7ta_back, uses m7ta_pkg.
module mode7_texel_address_unit #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240,
   parameter int SKY_ROWS = 70,
   parameter int TEX_W_LOG2 = 8,
   parameter int TEX_H_LOG2 = 8,
   parameter int SKY_W_LOG2 = 9
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [8:0] req_pixel_col,
   input  logic [7:0] req_pixel_row,
   output logic rsp_valid,
   output logic rsp_is_sky,
   output logic [9:0] rsp_tex_u,
   output logic [9:0] rsp_tex_v,
   output logic [8:0] rsp_fog_alpha,
   output logic rsp_depth_invalid,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   logic [9:0] focal_ff;
   logic [8:0] horizon_ff;
   logic [9:0] scale_ff;
   logic signed [23:0] xoff_ff, yoff_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic [15:0] scroll_ff;
   logic wr_en;
   logic [2:0] idx;

   m7ta_pkg::front_cfg_type fcfg;
   m7ta_pkg::back_cfg_type bcfg;
   logic front_valid, q_full, q_valid;
   m7ta_pkg::item_type front_item, q_item;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;
   assign idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= 10'd400;
         horizon_ff <= 9'd80;
         scale_ff <= 10'd60;
         xoff_ff <= '0;
         yoff_ff <= '0;
         cos_ff <= 16'sd16384;
         sin_ff <= '0;
         scroll_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            m7ta_pkg::REG_FOCAL_LENGTH: focal_ff <= pwdata[9:0];
            m7ta_pkg::REG_HORIZON: horizon_ff <= pwdata[8:0];
            m7ta_pkg::REG_GROUND_SCALE: scale_ff <= pwdata[9:0];
            m7ta_pkg::REG_X_OFFSET: xoff_ff <= pwdata[23:0];
            m7ta_pkg::REG_Y_OFFSET: yoff_ff <= pwdata[23:0];
            m7ta_pkg::REG_COS_ANGLE: cos_ff <= pwdata[15:0];
            m7ta_pkg::REG_SIN_ANGLE: sin_ff <= pwdata[15:0];
            m7ta_pkg::REG_SKY_SCROLL: scroll_ff <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         m7ta_pkg::REG_FOCAL_LENGTH: prdata = {22'd0, focal_ff};
         m7ta_pkg::REG_HORIZON: prdata = {23'd0, horizon_ff};
         m7ta_pkg::REG_GROUND_SCALE: prdata = {22'd0, scale_ff};
         m7ta_pkg::REG_X_OFFSET: prdata = {{8{xoff_ff[23]}}, xoff_ff};
         m7ta_pkg::REG_Y_OFFSET: prdata = {{8{yoff_ff[23]}}, yoff_ff};
         m7ta_pkg::REG_COS_ANGLE: prdata = {{16{cos_ff[15]}}, cos_ff};
         m7ta_pkg::REG_SIN_ANGLE: prdata = {{16{sin_ff[15]}}, sin_ff};
         m7ta_pkg::REG_SKY_SCROLL: prdata = {16'd0, scroll_ff};
         default: prdata = 32'd0;
      endcase
   end

   always_comb begin
      fcfg.focal_length = focal_ff;
      fcfg.horizon = horizon_ff;
      fcfg.sky_scroll = scroll_ff;
      bcfg.ground_scale = scale_ff;
      bcfg.x_offset = xoff_ff;
      bcfg.y_offset = yoff_ff;
      bcfg.cos_angle = cos_ff;
      bcfg.sin_angle = sin_ff;
   end

   assign busy = q_full;

   m7ta_front #(
      .SCREEN_W(SCREEN_W),
      .SCREEN_H(SCREEN_H),
      .SKY_ROWS(SKY_ROWS),
      .SKY_W_LOG2(SKY_W_LOG2)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(start && !busy),
      .pixel_col(req_pixel_col),
      .pixel_row(req_pixel_row),
      .cfg(fcfg),
      .out_valid(front_valid),
      .out_item(front_item)
   );

   m7ta_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(front_valid),
      .push_item(front_item),
      .pop(1'b1),
      .full(q_full),
      .out_valid(q_valid),
      .out_item(q_item)
   );

   m7ta_back #(
      .TEX_W_LOG2(TEX_W_LOG2),
      .TEX_H_LOG2(TEX_H_LOG2)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(q_valid),
      .in_item(q_item),
      .cfg(bcfg),
      .out_valid(rsp_valid),
      .is_sky(rsp_is_sky),
      .tex_u(rsp_tex_u),
      .tex_v(rsp_tex_v),
      .fog_alpha(rsp_fog_alpha),
      .depth_invalid(rsp_depth_invalid)
   );

endmodule

>>> rtl/core/m7ta_checker.sv
// Port-level checker for the texel address unit and its bind statement.
// Depends on m7ta_pkg and mode7_texel_address_unit.
module m7ta_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic rsp_valid,
   input  logic rsp_is_sky,
   input  logic [9:0] rsp_tex_u,
   input  logic [9:0] rsp_tex_v,
   input  logic [8:0] rsp_fog_alpha,
   input  logic rsp_depth_invalid
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(m7ta_pkg::LATENCY) rsp_valid)
      else $error("request gave no response at the expected cycle");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, m7ta_pkg::LATENCY))
      else $error("response without a matching request");

   a_sky_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_sky) |-> (!rsp_depth_invalid && rsp_fog_alpha == 9'd0))
      else $error("sky response carries ground fields");

   a_bad_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_depth_invalid) |-> (rsp_tex_u == 10'd0 && rsp_tex_v == 10'd0))
      else $error("invalid depth response has a nonzero address");

endmodule

bind mode7_texel_address_unit m7ta_checker u_m7ta_checker (.*);

>>> bench/tb_mode7_texel_address_unit.sv
// Self-checking testbench for the Mode 7 texel address unit.
// Drives pixel requests and register writes, predicts each response in the bench.
// Depends on m7ta_pkg and mode7_texel_address_unit.
`timescale 1ns / 1ps

module tb_mode7_texel_address_unit;

   localparam int SKY_ROWS_TB = 70;
   localparam int SCREEN_HALF_W = 160;
   localparam int SCREEN_HALF_H = 120;

   typedef struct packed {
      logic is_sky;
      logic [9:0] tex_u;
      logic [9:0] tex_v;
      logic [8:0] fog_alpha;
      logic depth_invalid;
   } texel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [8:0] req_pixel_col = '0;
   logic [7:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_is_sky;
   logic [9:0] rsp_tex_u;
   logic [9:0] rsp_tex_v;
   logic [8:0] rsp_fog_alpha;
   logic rsp_depth_invalid;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int cfg_focal = 400;
   int cfg_horizon = 80;
   int cfg_scale = 60;
   int cfg_xoff = 0;
   int cfg_yoff = 0;
   int cfg_cos = 16384;
   int cfg_sin = 0;
   int cfg_scroll = 0;

   texel_type pending_texels[$];
   int mismatches = 0;
   int send_idle_pct = 0;

   mode7_texel_address_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_col(req_pixel_col), .req_pixel_row(req_pixel_row),
      .rsp_valid(rsp_valid), .rsp_is_sky(rsp_is_sky), .rsp_tex_u(rsp_tex_u),
      .rsp_tex_v(rsp_tex_v), .rsp_fog_alpha(rsp_fog_alpha),
      .rsp_depth_invalid(rsp_depth_invalid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic texel_type predict_texel(input logic [8:0] col, input logic [7:0] row);
      texel_type t;
      longint cx, cy, num, den, qx, qy, rx, ry, sx, sy, tx, ty;
      int f;
      t = '0;
      if (int'(row) < SKY_ROWS_TB) begin
         t.is_sky = 1'b1;
         t.tex_u = 10'((int'(col) + cfg_scroll) & 511);
         t.tex_v = 10'(row);
      end else begin
         f = ((int'(row) - 60) * -100) / 110 - 10;
         if (f < -100) f = -100;
         if (f > 0) f = 0;
         t.fog_alpha = 9'(f & 505);
         cx = longint'(col) - SCREEN_HALF_W;
         cy = longint'(row) - SCREEN_HALF_H;
         num = cy + cfg_focal;
         den = cy + cfg_horizon;
         if (den <= 0) begin
            t.depth_invalid = 1'b1;
         end else begin
            qx = (cx * 65536) / den;
            qy = (-num * 65536) / den;
            rx = qx * cfg_cos - qy * cfg_sin;
            ry = qx * cfg_sin + qy * cfg_cos;
            sx = rx * cfg_scale + longint'(cfg_xoff) * 4194304;
            sy = ry * cfg_scale + longint'(cfg_yoff) * 4194304;
            tx = sx / 1073741824;
            ty = sy / 1073741824;
            t.tex_u = 10'(tx & 255);
            t.tex_v = 10'(ty & 255);
         end
      end
      return t;
   endfunction

   always @(posedge clock) begin
      texel_type want;
      texel_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_is_sky, rsp_tex_u, rsp_tex_v, rsp_fog_alpha, rsp_depth_invalid};
         if (pending_texels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_texels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: sky %b/%b u %0d/%0d v %0d/%0d fog %0d/%0d bad %b/%b",
                     want.is_sky, got.is_sky, want.tex_u, got.tex_u, want.tex_v,
                     got.tex_v, want.fog_alpha, got.fog_alpha, want.depth_invalid,
                     got.depth_invalid);
            end
         end
      end
   end

   // Called at a rising edge; returns at a rising edge.
   task automatic send_pixel(input logic [8:0] col, input logic [7:0] row);
      start <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (busy);
      pending_texels.push_back(predict_texel(col, row));
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (m7ta_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         m7ta_pkg::REG_FOCAL_LENGTH: cfg_focal = value & 1023;
         m7ta_pkg::REG_HORIZON: cfg_horizon = value & 511;
         m7ta_pkg::REG_GROUND_SCALE: cfg_scale = value & 1023;
         m7ta_pkg::REG_X_OFFSET: cfg_xoff = int'($signed(value[23:0]));
         m7ta_pkg::REG_Y_OFFSET: cfg_yoff = int'($signed(value[23:0]));
         m7ta_pkg::REG_COS_ANGLE: cfg_cos = int'($signed(value[15:0]));
         m7ta_pkg::REG_SIN_ANGLE: cfg_sin = int'($signed(value[15:0]));
         m7ta_pkg::REG_SKY_SCROLL: cfg_scroll = value & 65535;
         default: begin
         end
      endcase
   endtask

   task automatic write_all(input int fl, input int hz, input int sc, input int xo,
                            input int yo, input int cs, input int sn, input int sk);
      write_reg(m7ta_pkg::REG_FOCAL_LENGTH, fl);
      write_reg(m7ta_pkg::REG_HORIZON, hz);
      write_reg(m7ta_pkg::REG_GROUND_SCALE, sc);
      write_reg(m7ta_pkg::REG_X_OFFSET, xo);
      write_reg(m7ta_pkg::REG_Y_OFFSET, yo);
      write_reg(m7ta_pkg::REG_COS_ANGLE, cs);
      write_reg(m7ta_pkg::REG_SIN_ANGLE, sn);
      write_reg(m7ta_pkg::REG_SKY_SCROLL, sk);
   endtask

   task automatic test_reset_defaults();
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd511, 8'd255);
      send_pixel(9'd319, 8'd69);
      send_pixel(9'd0, 8'd70);
      send_pixel(9'd160, 8'd120);
      send_pixel(9'd319, 8'd239);
      send_pixel(9'd511, 8'd69);
      send_pixel(9'd255, 8'd159);
      send_pixel(9'd0, 8'd60);
      send_pixel(9'd100, 8'd158);
      drain_responses();
   endtask

   task automatic test_bad_depth();
      write_reg(m7ta_pkg::REG_HORIZON, 0);
      send_pixel(9'd10, 8'd70);
      send_pixel(9'd10, 8'd120);
      send_pixel(9'd10, 8'd121);
      drain_responses();
      write_reg(m7ta_pkg::REG_HORIZON, 50);
      send_pixel(9'd300, 8'd70);
      send_pixel(9'd300, 8'd71);
      drain_responses();
   endtask

   task automatic test_register_extremes();
      write_all(1023, 511, 1023, 8388607, 8388607, 16384, 16384, 65535);
      send_pixel(9'd0, 8'd255);
      send_pixel(9'd511, 8'd70);
      send_pixel(9'd511, 8'd0);
      send_pixel(9'd319, 8'd200);
      drain_responses();
      write_all(0, 0, 0, -8388608, -8388608, -16384, -16384, 0);
      send_pixel(9'd0, 8'd255);
      send_pixel(9'd511, 8'd200);
      send_pixel(9'd1, 8'd1);
      drain_responses();
   endtask

   task automatic random_pixels(input int count);
      logic [8:0] col;
      logic [7:0] row;
      for (int i = 0; i < count; i++) begin
         col = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(319));
         row = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(239));
         send_pixel(col, row);
      end
      drain_responses();
   endtask

   task automatic test_random(input int idle_pct);
      send_idle_pct = idle_pct;
      for (int p = 0; p < 3; p++) begin
         write_all($urandom_range(1023), $urandom_range(511), $urandom_range(1023),
                   $urandom, $urandom, int'($urandom_range(32768)) - 16384,
                   int'($urandom_range(32768)) - 16384, $urandom_range(65535));
         random_pixels(160);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_bad_depth();
      test_register_extremes();
      test_random(36);
      test_random(67);
      test_random(0);
      if (mismatches == 0 && pending_texels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
